[rtl/pcls_pkg.sv]
// ----------------------------------------------------------------------------
// pcls_pkg
// Shared types and constants of the per-class latency statistics monitor.
// ----------------------------------------------------------------------------
package pcls_pkg;

  localparam int NUM_CLASSES_DEF = 32;
  localparam int IDX_W           = 5;
  localparam int CMD_W           = 2;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 360;

  localparam logic [CMD_W-1:0] CMD_ISSUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CPL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd2;

  typedef struct packed {
    logic [2:0]       pad;
    logic [31:0]      completed_interval;
    logic [31:0]      completed_total;
    logic [31:0]      issued_interval;
    logic [31:0]      issued_total;
    logic [31:0]      interval_max;
    logic [47:0]      interval_sum;
    logic [31:0]      interval_count;
    logic [31:0]      total_max;
    logic [47:0]      total_sum;
    logic [31:0]      total_count;
    logic [IDX_W-1:0] class_index;
  } out_data_t;

  typedef struct packed {
    logic issue;
    logic cpl_rd;
    logic cpl_wr;
    logic dump_start;
    logic dump_rd;
    logic dump_next;
    logic dump_end;
  } pcls_cmd_t;

  typedef struct packed {
    logic cls_ok;
    logic dump_last;
  } pcls_sts_t;

endpackage

[rtl/per_class_latency_stats.sv]
// ----------------------------------------------------------------------------
// per_class_latency_stats
// Per-class completion count, latency sum and maximum, whole run and interval.
// ----------------------------------------------------------------------------
// An issue transfer is taken while in_tready stays high; a completion transfer
// for a valid class drops in_tready for the read-modify-write of the statistics
// table through its one port. A dump reads the table (ST_DUMP_RD) and then offers
// the result (ST_DUMP_OUT) for each reported class in turn from class one, going
// on only once out_tready takes the result. Reset is synchronous; per-entry valid
// flags clear the table, so there is no clearing pass and in_tready is high right after reset.
module per_class_latency_stats #(
  parameter int NUM_CLASSES = pcls_pkg::NUM_CLASSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [4:0] op_class, [36:5] elapsed_us, [39:37] zero.
  input  logic [pcls_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] command.
  input  logic [pcls_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] class_index, [36:5] total_count, [84:37] total_sum,
  // [116:85] total_max, [148:117] interval_count, [196:149] interval_sum,
  // [228:197] interval_max, [260:229] issued_total, [292:261] issued_interval,
  // [324:293] completed_total, [356:325] completed_interval, [359:357] zero.
  output logic [pcls_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  pcls_pkg::pcls_cmd_t cmd;
  pcls_pkg::pcls_sts_t sts;
  pcls_pkg::out_data_t out_data;

  pcls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pcls_dp #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op_class   (in_tdata[4:0]),
    .in_elapsed_us (in_tdata[36:5]),
    .out_data      (out_data),
    .out_last      (out_tlast)
  );

  assign out_tdata = out_data;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("input not ready after final dump result");

  a_dump_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == pcls_pkg::CMD_DUMP)) |->
    ##2 (out_tvalid && (out_tdata[4:0] == 5'd1)))
    else $error("dump did not start at class one");

  a_dump_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |->
    ##2 (out_tvalid && (out_tdata[4:0] == $past(out_tdata[4:0], 2) + 5'd1)))
    else $error("dump class sequence broken");
`endif

endmodule

[rtl/pcls_ctrl.sv]
// ----------------------------------------------------------------------------
// pcls_ctrl
// Sequencer for issue, completion and dump transfers of the statistics block.
// ----------------------------------------------------------------------------
module pcls_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [pcls_pkg::CMD_W-1:0] in_command,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  pcls_pkg::pcls_sts_t        sts,
  output pcls_pkg::pcls_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CPL_WR,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;
  logic   acc;
  logic   out_done;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;
  assign acc        = in_tvalid && in_tready_r;
  assign out_done   = out_tvalid_r && out_tready;

  always_comb begin
    cmd            = '0;
    cmd.issue      = (state_r == ST_IDLE) && acc && (in_command == pcls_pkg::CMD_ISSUE);
    cmd.cpl_rd     = (state_r == ST_IDLE) && acc && (in_command == pcls_pkg::CMD_CPL) &&
                     sts.cls_ok;
    cmd.dump_start = (state_r == ST_IDLE) && acc && (in_command == pcls_pkg::CMD_DUMP);
    cmd.cpl_wr     = (state_r == ST_CPL_WR);
    cmd.dump_rd    = (state_r == ST_DUMP_RD);
    cmd.dump_next  = (state_r == ST_DUMP_OUT) && out_done && !sts.dump_last;
    cmd.dump_end   = (state_r == ST_DUMP_OUT) && out_done && sts.dump_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.cpl_rd) begin
            state_r     <= ST_CPL_WR;
            in_tready_r <= 1'b0;
          end else if (cmd.dump_start) begin
            state_r     <= ST_DUMP_RD;
            in_tready_r <= 1'b0;
          end
        end
        ST_CPL_WR: begin
          state_r     <= ST_IDLE;
          in_tready_r <= 1'b1;
        end
        ST_DUMP_RD: begin
          state_r      <= ST_DUMP_OUT;
          out_tvalid_r <= 1'b1;
        end
        ST_DUMP_OUT: begin
          if (out_done) begin
            out_tvalid_r <= 1'b0;
            if (sts.dump_last) begin
              state_r     <= ST_IDLE;
              in_tready_r <= 1'b1;
            end else begin
              state_r <= ST_DUMP_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/pcls_dp.sv]
// ----------------------------------------------------------------------------
// pcls_dp
// Statistics table, request counters and dump result register.
// ----------------------------------------------------------------------------
module pcls_dp #(
  parameter int NUM_CLASSES = pcls_pkg::NUM_CLASSES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcls_pkg::pcls_cmd_t        cmd,
  output pcls_pkg::pcls_sts_t        sts,
  input  logic [pcls_pkg::IDX_W-1:0] in_op_class,
  input  logic [31:0]                in_elapsed_us,
  output pcls_pkg::out_data_t        out_data,
  output logic                       out_last
);

  localparam int CLS_W    = $clog2(NUM_CLASSES);
  localparam int REPORTED = (NUM_CLASSES < 32) ? NUM_CLASSES : 32;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] sum;
    logic [31:0] max;
  } stats_t;

  typedef struct packed {
    stats_t run;
    stats_t win;
  } entry_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (&v) ? v : v + 32'd1;
  endfunction

  function automatic stats_t upd(input stats_t s, input logic [31:0] e);
    logic [48:0] sum_w;
    sum_w     = {1'b0, s.sum} + {17'd0, e};
    upd.count = sat_inc(s.count);
    upd.sum   = sum_w[48] ? {48{1'b1}} : sum_w[47:0];
    upd.max   = (e > s.max) ? e : s.max;
  endfunction

  entry_t                     mem [NUM_CLASSES];
  entry_t                     rd_r;
  logic                       run_hit_r;
  logic                       win_hit_r;
  logic [NUM_CLASSES-1:0]     run_vld_r;
  logic [NUM_CLASSES-1:0]     win_vld_r;
  logic [CLS_W-1:0]           raddr;
  logic [CLS_W-1:0]           cls_r;
  logic [31:0]                elapsed_r;
  logic [pcls_pkg::IDX_W-1:0] k_r;
  logic [31:0]                issued_run_r;
  logic [31:0]                issued_win_r;
  logic [31:0]                completed_run_r;
  logic [31:0]                completed_win_r;
  stats_t                     run_s;
  stats_t                     win_s;
  entry_t                     wr_entry;

  assign raddr = cmd.dump_rd ? CLS_W'(k_r) : CLS_W'(in_op_class);
  assign run_s = run_hit_r ? rd_r.run : '0;
  assign win_s = win_hit_r ? rd_r.win : '0;

  assign wr_entry.run = upd(run_s, elapsed_r);
  assign wr_entry.win = upd(win_s, elapsed_r);

  assign sts.cls_ok    = (32'(in_op_class) < NUM_CLASSES);
  assign sts.dump_last = (k_r == pcls_pkg::IDX_W'(REPORTED - 1));

  always_ff @(posedge clk) begin
    if (cmd.cpl_rd || cmd.dump_rd) begin
      rd_r      <= mem[raddr];
      run_hit_r <= run_vld_r[raddr];
      win_hit_r <= win_vld_r[raddr];
    end
    if (cmd.cpl_rd) begin
      cls_r     <= CLS_W'(in_op_class);
      elapsed_r <= in_elapsed_us;
    end
    if (cmd.cpl_wr) begin
      mem[cls_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_vld_r       <= '0;
      win_vld_r       <= '0;
      k_r             <= '0;
      issued_run_r    <= '0;
      issued_win_r    <= '0;
      completed_run_r <= '0;
      completed_win_r <= '0;
    end else begin
      if (cmd.issue) begin
        issued_run_r <= sat_inc(issued_run_r);
        issued_win_r <= sat_inc(issued_win_r);
      end
      if (cmd.cpl_wr) begin
        run_vld_r[cls_r] <= 1'b1;
        win_vld_r[cls_r] <= 1'b1;
        completed_run_r  <= sat_inc(completed_run_r);
        completed_win_r  <= sat_inc(completed_win_r);
      end
      if (cmd.dump_start) begin
        k_r <= pcls_pkg::IDX_W'(1);
      end else if (cmd.dump_next) begin
        k_r <= k_r + pcls_pkg::IDX_W'(1);
      end
      if (cmd.dump_end) begin
        win_vld_r       <= '0;
        issued_win_r    <= '0;
        completed_win_r <= '0;
      end
    end
  end

  always_comb begin
    out_data                    = '0;
    out_data.class_index        = k_r;
    out_data.total_count        = run_s.count;
    out_data.total_sum          = run_s.sum;
    out_data.total_max          = run_s.max;
    out_data.interval_count     = win_s.count;
    out_data.interval_sum       = win_s.sum;
    out_data.interval_max       = win_s.max;
    out_data.issued_total       = issued_run_r;
    out_data.issued_interval    = issued_win_r;
    out_data.completed_total    = completed_run_r;
    out_data.completed_interval = completed_win_r;
  end

  assign out_last = sts.dump_last;

endmodule
